/* design/ttf_pkg.sv */
// ttf_pkg: shared types and constants for the triangle tangent frame block
// used by ttf_ctrl, ttf_dp and triangle_tangent_frame; no dependencies
package ttf_pkg;

  localparam int POS_W    = 24;
  localparam int TEX_W    = 20;
  localparam int OUT_W    = 16;
  localparam int EDGE_W   = POS_W + 1;
  localparam int DELTA_W  = TEX_W + 1;
  localparam int DET_W    = 2 * DELTA_W + 1;
  localparam int VEC_W    = 48;
  localparam int OPND_W   = 32;
  localparam int PROD_W   = 62;
  localparam int NORM_W   = 30;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 64;
  localparam int LEN_W    = 32;
  localparam int QUO_W    = 15;
  localparam int DVS_W    = LEN_W + 1;
  localparam int REM_W    = DVS_W + QUO_W - 1;
  localparam int STEP_W   = 5;
  localparam int IN_W     = 3 * POS_W + 2 * TEX_W;
  localparam int FRAME_N  = 9;

  localparam logic [STEP_W-1:0] K_TB_LAST     = 5'd13;
  localparam logic [STEP_W-1:0] K_CROSS_FIRST = 5'd14;
  localparam logic [STEP_W-1:0] K_CROSS_LAST  = 5'd19;
  localparam logic [STEP_W-1:0] K_SQ_LAST     = 5'd2;
  localparam logic [STEP_W-1:0] K_SQRT_FIRST  = 5'd31;
  localparam logic [STEP_W-1:0] K_DIV_FIRST   = 5'd14;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    VS_TAN,
    VS_BIN,
    VS_NRM
  } vec_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_NLOAD,
    ST_SHIFT,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_WB,
    ST_FAIL,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_HOLD1,
    DP_HOLD2,
    DP_EDGE,
    DP_MUL,
    DP_ACC,
    DP_NLOAD,
    DP_SHIFT,
    DP_SQMUL,
    DP_SQACC,
    DP_SQRT_INIT,
    DP_SQRT,
    DP_DIV_INIT,
    DP_DIV,
    DP_WB,
    DP_FAIL,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STEP_W-1:0]   k;
    vec_sel_e            src;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic mag_zero;
    logic need_right;
    logic need_left;
    logic out_free;
  } dp_status_t;

endpackage

/* design/triangle_tangent_frame.sv */
// triangle_tangent_frame: per-triangle unit tangent, binormal and normal
// depends on ttf_pkg, ttf_ctrl and ttf_dp
//
//   channel  | dir | word contents
//   s_axis   | in  | one vertex: position x/y/z Q8.16, texture u/v Q4.16
//   m_axis   | out | one frame per triangle: tangent, binormal, normal Q1.14
//
// the first two vertices of a triangle are taken while idle and only held
// the third runs on one shared 32x32 multiplier, a one-bit-a-cycle square root
// and three radix-2 dividers; the time to a valid frame varies with the
// one-bit-a-cycle normalizing shifter, and a degenerate triangle ends sooner
// no vertex is taken meanwhile
// reset clears the vertex count and the output valid; held vertices are not cleared
// a stalled output holds the next frame back in its final state
module triangle_tangent_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [ttf_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tangent_x/y/z, binormal_x/y/z, normal_x/y/z
  output logic [ttf_pkg::FRAME_N*ttf_pkg::OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic                         m_axis_tuser
);
  import ttf_pkg::*;

  dp_cmd_t                       cmd;
  dp_status_t                    status;
  logic signed [POS_W-1:0]       pos_x, pos_y, pos_z;
  logic signed [TEX_W-1:0]       tex_u, tex_v;
  logic [FRAME_N-1:0][OUT_W-1:0] frame;

  assign pos_x = s_axis_tdata[POS_W-1:0];
  assign pos_y = s_axis_tdata[2*POS_W-1:POS_W];
  assign pos_z = s_axis_tdata[3*POS_W-1:2*POS_W];
  assign tex_u = s_axis_tdata[3*POS_W+TEX_W-1:3*POS_W];
  assign tex_v = s_axis_tdata[IN_W-1:3*POS_W+TEX_W];

  ttf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .tex_u_i      (tex_u),
    .tex_v_i      (tex_v),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .frame_o      (frame),
    .degenerate_o (m_axis_tuser)
  );

  assign m_axis_tdata = frame;

endmodule

/* design/ttf_ctrl.sv */
// ttf_ctrl: sequencer for vertex intake, products, normalization and output
// depends on ttf_pkg; drives ttf_dp through command and status structs
module ttf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttf_pkg::dp_status_t status_i,
  output ttf_pkg::dp_cmd_t    cmd_o
);
  import ttf_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] k_q, k_d;
  vec_sel_e          src_q, src_d;
  logic [1:0]        phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      src_q   <= VS_TAN;
      phase_q <= PH_FIRST;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      src_q   <= src_d;
      phase_q <= phase_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    src_d   = src_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (phase_q == PH_THIRD) begin
            phase_d = PH_FIRST;
            state_d = ST_MUL;
            k_d     = '0;
          end else if (phase_q == PH_SECOND) begin
            phase_d = PH_THIRD;
          end else begin
            phase_d = PH_SECOND;
          end
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        priority if (k_q == K_TB_LAST) begin
          if (status_i.det_zero) begin
            state_d = ST_FAIL;
          end else begin
            state_d = ST_NLOAD;
            src_d   = VS_TAN;
          end
        end else if (k_q == K_CROSS_LAST) begin
          state_d = ST_NLOAD;
          src_d   = VS_NRM;
        end else begin
          state_d = ST_MUL;
          k_d     = k_q + 1'b1;
        end
      end
      ST_NLOAD: state_d = ST_SHIFT;
      ST_SHIFT: begin
        priority if (status_i.mag_zero) begin
          state_d = ST_FAIL;
        end else if (!status_i.need_right && !status_i.need_left) begin
          state_d = ST_SQMUL;
          k_d     = '0;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SQMUL: state_d = ST_SQACC;
      ST_SQACC: begin
        if (k_q == K_SQ_LAST) begin
          state_d = ST_SQRT_INIT;
        end else begin
          state_d = ST_SQMUL;
          k_d     = k_q + 1'b1;
        end
      end
      ST_SQRT_INIT: begin
        state_d = ST_SQRT;
        k_d     = K_SQRT_FIRST;
      end
      ST_SQRT: begin
        if (k_q == '0) begin
          state_d = ST_DIV_INIT;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_DIV_INIT: begin
        state_d = ST_DIV;
        k_d     = K_DIV_FIRST;
      end
      ST_DIV: begin
        if (k_q == '0) begin
          state_d = ST_WB;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_WB: begin
        unique case (src_q)
          VS_TAN: begin
            state_d = ST_NLOAD;
            src_d   = VS_BIN;
          end
          VS_BIN: begin
            state_d = ST_MUL;
            k_d     = K_CROSS_FIRST;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_FAIL: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.k    = k_q;
    cmd_o.src  = src_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority if (phase_q == PH_THIRD) begin
            cmd_o.op = DP_EDGE;
          end else if (phase_q == PH_SECOND) begin
            cmd_o.op = DP_HOLD2;
          end else begin
            cmd_o.op = DP_HOLD1;
          end
        end
      end
      ST_MUL:       cmd_o.op = DP_MUL;
      ST_ACC:       cmd_o.op = DP_ACC;
      ST_NLOAD:     cmd_o.op = DP_NLOAD;
      ST_SHIFT:     cmd_o.op = DP_SHIFT;
      ST_SQMUL:     cmd_o.op = DP_SQMUL;
      ST_SQACC:     cmd_o.op = DP_SQACC;
      ST_SQRT_INIT: cmd_o.op = DP_SQRT_INIT;
      ST_SQRT:      cmd_o.op = DP_SQRT;
      ST_DIV_INIT:  cmd_o.op = DP_DIV_INIT;
      ST_DIV:       cmd_o.op = DP_DIV;
      ST_WB:        cmd_o.op = DP_WB;
      ST_FAIL:      cmd_o.op = DP_FAIL;
      ST_DONE:      cmd_o.op = status_i.out_free ? DP_OUT : DP_NOP;
      default:      cmd_o.op = DP_NOP;
    endcase
  end

endmodule

/* design/ttf_dp.sv */
// ttf_dp: held vertices, shared multiplier, accumulator, square root and divider
// depends on ttf_pkg; sequenced by ttf_ctrl
module ttf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ttf_pkg::dp_cmd_t                       cmd_i,
  output ttf_pkg::dp_status_t                    status_o,
  input  logic signed [ttf_pkg::POS_W-1:0]       pos_x_i,
  input  logic signed [ttf_pkg::POS_W-1:0]       pos_y_i,
  input  logic signed [ttf_pkg::POS_W-1:0]       pos_z_i,
  input  logic signed [ttf_pkg::TEX_W-1:0]       tex_u_i,
  input  logic signed [ttf_pkg::TEX_W-1:0]       tex_v_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [ttf_pkg::FRAME_N-1:0][ttf_pkg::OUT_W-1:0] frame_o,
  output logic                                   degenerate_o
);
  import ttf_pkg::*;

  logic signed [POS_W-1:0]   pin [3];
  logic signed [POS_W-1:0]   hp1_q [3];
  logic signed [POS_W-1:0]   hp2_q [3];
  logic signed [TEX_W-1:0]   ht1_q [2];
  logic signed [TEX_W-1:0]   ht2_q [2];
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [OPND_W-1:0]  opa, opb;
  logic signed [2*OPND_W-1:0] mul_full;
  logic [PROD_W-1:0]         prod_q;
  logic signed [VEC_W-1:0]   acc_q;
  logic signed [VEC_W-1:0]   acc_res;
  logic signed [DET_W-1:0]   det_q;
  logic signed [VEC_W-1:0]   vec_q [3][3];
  logic [1:0]                wr_src;
  logic [1:0]                wr_idx;
  logic                      wr_vec;
  logic [VEC_W-1:0]          mag_q [3];
  logic                      sgn_q [3];
  logic [VEC_W-1:0]          nmag [3];
  logic                      nsgn [3];
  logic [SUM_W-1:0]          sum_q;
  logic [ROOT_W-1:0]         rn_q, r_q;
  logic [ROOT_W-1:0]         sq_bit, sq_trial;
  logic [DVS_W-1:0]          dvs_q;
  logic [REM_W-1:0]          rem_q [3];
  logic [REM_W-1:0]          div_sh;
  logic [QUO_W-1:0]          quo_q [3];
  logic signed [OUT_W-1:0]   unit_q [3][3];
  logic signed [OUT_W-1:0]   wb_val [3];
  logic                      deg_q;
  logic                      out_valid_q;
  logic [FRAME_N-1:0][OUT_W-1:0] frame_q;
  logic                      deg_out_q;
  logic                      hi30, hi29;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    if (cmd_i.op == DP_SQMUL) begin
      opa = OPND_W'(mag_q[cmd_i.k[1:0]][NORM_W-1:0]);
      opb = OPND_W'(mag_q[cmd_i.k[1:0]][NORM_W-1:0]);
    end else begin
      unique case (cmd_i.k)
        5'd0:  begin opa = OPND_W'(du1_q); opb = OPND_W'(dv2_q); end
        5'd1:  begin opa = OPND_W'(du2_q); opb = OPND_W'(dv1_q); end
        5'd2:  begin opa = OPND_W'(dv2_q); opb = OPND_W'(e1_q[0]); end
        5'd3:  begin opa = OPND_W'(dv1_q); opb = OPND_W'(e2_q[0]); end
        5'd4:  begin opa = OPND_W'(dv2_q); opb = OPND_W'(e1_q[1]); end
        5'd5:  begin opa = OPND_W'(dv1_q); opb = OPND_W'(e2_q[1]); end
        5'd6:  begin opa = OPND_W'(dv2_q); opb = OPND_W'(e1_q[2]); end
        5'd7:  begin opa = OPND_W'(dv1_q); opb = OPND_W'(e2_q[2]); end
        5'd8:  begin opa = OPND_W'(du1_q); opb = OPND_W'(e2_q[0]); end
        5'd9:  begin opa = OPND_W'(du2_q); opb = OPND_W'(e1_q[0]); end
        5'd10: begin opa = OPND_W'(du1_q); opb = OPND_W'(e2_q[1]); end
        5'd11: begin opa = OPND_W'(du2_q); opb = OPND_W'(e1_q[1]); end
        5'd12: begin opa = OPND_W'(du1_q); opb = OPND_W'(e2_q[2]); end
        5'd13: begin opa = OPND_W'(du2_q); opb = OPND_W'(e1_q[2]); end
        5'd14: begin opa = OPND_W'(unit_q[0][1]); opb = OPND_W'(unit_q[1][2]); end
        5'd15: begin opa = OPND_W'(unit_q[0][2]); opb = OPND_W'(unit_q[1][1]); end
        5'd16: begin opa = OPND_W'(unit_q[0][2]); opb = OPND_W'(unit_q[1][0]); end
        5'd17: begin opa = OPND_W'(unit_q[0][0]); opb = OPND_W'(unit_q[1][2]); end
        5'd18: begin opa = OPND_W'(unit_q[0][0]); opb = OPND_W'(unit_q[1][1]); end
        5'd19: begin opa = OPND_W'(unit_q[0][1]); opb = OPND_W'(unit_q[1][0]); end
        default: begin opa = '0; opb = '0; end
      endcase
    end
  end

  assign mul_full = opa * opb;
  assign acc_res  = acc_q - signed'(prod_q[VEC_W-1:0]);

  // destination of a finished difference of products
  always_comb begin
    wr_vec = 1'b0;
    wr_src = 2'd0;
    wr_idx = 2'd0;
    priority if (cmd_i.k >= 5'd3 && cmd_i.k <= 5'd7) begin
      wr_vec = 1'b1;
      wr_src = 2'd0;
      wr_idx = 2'((cmd_i.k - 5'd3) >> 1);
    end else if (cmd_i.k >= 5'd9 && cmd_i.k <= K_TB_LAST) begin
      wr_vec = 1'b1;
      wr_src = 2'd1;
      wr_idx = 2'((cmd_i.k - 5'd9) >> 1);
    end else if (cmd_i.k >= 5'd15 && cmd_i.k <= K_CROSS_LAST) begin
      wr_vec = 1'b1;
      wr_src = 2'd2;
      wr_idx = 2'((cmd_i.k - 5'd15) >> 1);
    end else begin
      wr_vec = 1'b0;
    end
  end

  // magnitude and sign of the selected vector; tangent and binormal follow sign of det
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsgn[i] = vec_q[cmd_i.src][i][VEC_W-1] ^
                ((cmd_i.src != VS_NRM) && det_q[DET_W-1]);
      nmag[i] = vec_q[cmd_i.src][i][VEC_W-1] ? VEC_W'(-vec_q[cmd_i.src][i])
                                             : VEC_W'(vec_q[cmd_i.src][i]);
      wb_val[i] = sgn_q[i] ? -signed'(OUT_W'(quo_q[i])) : signed'(OUT_W'(quo_q[i]));
    end
  end

  assign hi30 = (mag_q[0][VEC_W-1:NORM_W] != '0) || (mag_q[1][VEC_W-1:NORM_W] != '0) ||
                (mag_q[2][VEC_W-1:NORM_W] != '0);
  assign hi29 = (mag_q[0][VEC_W-1:NORM_W-1] != '0) || (mag_q[1][VEC_W-1:NORM_W-1] != '0) ||
                (mag_q[2][VEC_W-1:NORM_W-1] != '0);

  assign sq_bit   = ROOT_W'(1) << {cmd_i.k, 1'b0};
  assign sq_trial = r_q + sq_bit;
  assign div_sh   = REM_W'(dvs_q) << cmd_i.k[3:0];

  assign status_o.det_zero   = (det_q == '0);
  assign status_o.mag_zero   = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign status_o.need_right = hi30;
  assign status_o.need_left  = !hi29 && !status_o.mag_zero;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_HOLD1: begin
        for (int i = 0; i < 3; i++) hp1_q[i] <= pin[i];
        ht1_q[0] <= tex_u_i;
        ht1_q[1] <= tex_v_i;
      end
      DP_HOLD2: begin
        for (int i = 0; i < 3; i++) hp2_q[i] <= pin[i];
        ht2_q[0] <= tex_u_i;
        ht2_q[1] <= tex_v_i;
      end
      DP_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EDGE_W'(hp2_q[i]) - EDGE_W'(hp1_q[i]);
          e2_q[i] <= EDGE_W'(pin[i]) - EDGE_W'(hp1_q[i]);
        end
        du1_q <= DELTA_W'(ht2_q[0]) - DELTA_W'(ht1_q[0]);
        dv1_q <= DELTA_W'(ht2_q[1]) - DELTA_W'(ht1_q[1]);
        du2_q <= DELTA_W'(tex_u_i) - DELTA_W'(ht1_q[0]);
        dv2_q <= DELTA_W'(tex_v_i) - DELTA_W'(ht1_q[1]);
      end
      DP_MUL, DP_SQMUL: prod_q <= mul_full[PROD_W-1:0];
      DP_ACC: begin
        if (!cmd_i.k[0]) begin
          acc_q <= signed'(prod_q[VEC_W-1:0]);
        end else if (wr_vec) begin
          vec_q[wr_src][wr_idx] <= acc_res;
        end else begin
          det_q <= acc_res[DET_W-1:0];
        end
      end
      DP_NLOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= nmag[i];
          sgn_q[i] <= nsgn[i];
        end
      end
      DP_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (hi30) begin
            mag_q[i] <= mag_q[i] >> 1;
          end else if (!hi29) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      DP_SQACC: sum_q <= (cmd_i.k == '0 ? '0 : sum_q) + prod_q;
      DP_SQRT_INIT: begin
        rn_q <= ROOT_W'(sum_q);
        r_q  <= '0;
      end
      DP_SQRT: begin
        if (rn_q >= sq_trial) begin
          rn_q <= rn_q - sq_trial;
          r_q  <= (r_q >> 1) + sq_bit;
        end else begin
          r_q  <= r_q >> 1;
        end
      end
      DP_DIV_INIT: begin
        dvs_q <= {r_q[LEN_W-1:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= REM_W'({mag_q[i][NORM_W-1:0], {QUO_W{1'b0}}}) +
                      REM_W'(r_q[LEN_W-1:0]);
          quo_q[i] <= '0;
        end
      end
      DP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= div_sh) begin
            rem_q[i] <= rem_q[i] - div_sh;
            quo_q[i][cmd_i.k[3:0]] <= 1'b1;
          end
        end
      end
      DP_WB: begin
        for (int i = 0; i < 3; i++) unit_q[cmd_i.src][i] <= wb_val[i];
      end
      DP_OUT: begin
        for (int j = 0; j < 3; j++) begin
          for (int i = 0; i < 3; i++) begin
            frame_q[3*j+i] <= deg_q ? '0 : unit_q[j][i];
          end
        end
        deg_out_q <= deg_q;
      end
      default: ;
    endcase
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_EDGE) begin
        deg_q <= 1'b0;
      end else if (cmd_i.op == DP_FAIL) begin
        deg_q <= 1'b1;
      end
      if (cmd_i.op == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_o      = frame_q;
  assign degenerate_o = deg_out_q;

endmodule

/* tb/tb_triangle_tangent_frame.sv */
// tb_triangle_tangent_frame: self-checking testbench for the triangle tangent frame block
// streams vertices through a directed table and random triangles, checks every frame
// against a bit-exact predictor or a typed expectation; depends on ttf_pkg and triangle_tangent_frame
`timescale 1ns / 100ps

module tb_triangle_tangent_frame;
  import ttf_pkg::*;

  localparam int LIMIT_CYC = 1000000;
  localparam int HOLD_CYC  = 2000;
  localparam int PMAX = 8388607, PMIN = -8388608, TMAX = 524287, TMIN = -524288;
  localparam int ONE_P = 65536, ONE_T = 65536;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [TEX_W-1:0] u, v;
  } vertex_t;

  typedef struct {
    logic [FRAME_N*OUT_W-1:0] data;
    logic                     deg;
  } frame_t;

  typedef longint vec3_t[3];

  // typed expectations for directed rows
  typedef enum int {EXP_NONE, EXP_DEGEN, EXP_AXES} exp_kind_e;

  typedef struct {
    vertex_t   vtx;
    exp_kind_e kind;
  } row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [IN_W-1:0]              s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [FRAME_N*OUT_W-1:0]     m_axis_tdata;
  logic                         m_axis_tuser;

  frame_t    frame_q[$];
  row_t      rows[$];
  vertex_t   held_vtx[2];
  int        tri_phase = 0;
  exp_kind_e typed_kind = EXP_NONE;
  int        word_cnt = 0;
  int        err_cnt = 0;
  int        cyc_cnt = 0;
  int        recv_pct = 0;
  int        send_pct = 0;
  bit        hold_req = 0;

  triangle_tangent_frame i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit to_unit(input vec3_t vin, output vec3_t uo);
    longint unsigned mag[3];
    longint unsigned m, sum, len, q;
    int bl;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (vin[i] < 0) ? -vin[i] : vin[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 0;
    bl = 0;
    while (m != 0) begin
      m >>= 1;
      bl++;
    end
    for (int i = 0; i < 3; i++) begin
      if (bl > NORM_W) mag[i] >>= (bl - NORM_W);
      else if (bl < NORM_W) mag[i] <<= (NORM_W - bl);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 15) + len) / (2 * len);
      uo[i] = (vin[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic frame_t tangent_frame(input vertex_t a, input vertex_t b, input vertex_t c);
    frame_t f;
    vec3_t  e1, e2, tn, bn, cr, t, bv, n;
    longint du1, dv1, du2, dv2, det;
    bit     ok;
    e1 = '{longint'(b.px) - a.px, longint'(b.py) - a.py, longint'(b.pz) - a.pz};
    e2 = '{longint'(c.px) - a.px, longint'(c.py) - a.py, longint'(c.pz) - a.pz};
    du1 = longint'(b.u) - a.u;
    dv1 = longint'(b.v) - a.v;
    du2 = longint'(c.u) - a.u;
    dv2 = longint'(c.v) - a.v;
    det = du1 * dv2 - du2 * dv1;
    for (int i = 0; i < 3; i++) begin
      tn[i] = dv2 * e1[i] - dv1 * e2[i];
      bn[i] = du1 * e2[i] - du2 * e1[i];
      if (det < 0) begin
        tn[i] = -tn[i];
        bn[i] = -bn[i];
      end
    end
    ok = (det != 0) && to_unit(tn, t) && to_unit(bn, bv);
    if (ok) begin
      cr[0] = t[1] * bv[2] - t[2] * bv[1];
      cr[1] = t[2] * bv[0] - t[0] * bv[2];
      cr[2] = t[0] * bv[1] - t[1] * bv[0];
      ok = to_unit(cr, n);
    end
    f.data = '0;
    f.deg = !ok;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        f.data[OUT_W*i +: OUT_W]     = t[i][OUT_W-1:0];
        f.data[OUT_W*(3+i) +: OUT_W] = bv[i][OUT_W-1:0];
        f.data[OUT_W*(6+i) +: OUT_W] = n[i][OUT_W-1:0];
      end
    end
    return f;
  endfunction

  // input side: track the vertex count and queue the expected frame
  always @(posedge clk_i) begin
    vertex_t vt;
    frame_t  f;
    if (s_axis_tvalid && s_axis_tready) begin
      {vt.v, vt.u, vt.pz, vt.py, vt.px} = s_axis_tdata;
      word_cnt <= word_cnt + 1;
      if (tri_phase < 2) begin
        held_vtx[tri_phase] = vt;
        tri_phase = tri_phase + 1;
      end else begin
        tri_phase = 0;
        f = tangent_frame(held_vtx[0], held_vtx[1], vt);
        if (typed_kind == EXP_DEGEN) begin
          f.data = '0;
          f.deg = 1'b1;
        end else if (typed_kind == EXP_AXES) begin
          f.data = '0;
          f.deg = 1'b0;
          f.data[OUT_W*0 +: OUT_W] = 16'sd16384;
          f.data[OUT_W*4 +: OUT_W] = 16'sd16384;
          f.data[OUT_W*8 +: OUT_W] = 16'sd16384;
        end
        frame_q = {frame_q, f};
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    frame_t f;
    if (m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word: data %h deg %b", m_axis_tdata, m_axis_tuser);
      end else begin
        f = frame_q.pop_front();
        for (int i = 0; i < FRAME_N; i++)
          if (m_axis_tdata[OUT_W*i +: OUT_W] !== f.data[OUT_W*i +: OUT_W]) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("field %0d mismatch: exp %h got %h", i,
                       f.data[OUT_W*i +: OUT_W], m_axis_tdata[OUT_W*i +: OUT_W]);
          end
        if (m_axis_tuser !== f.deg) begin
          err_cnt++;
          if (err_cnt <= 10) $display("degenerate mismatch: exp %b got %b", f.deg, m_axis_tuser);
        end
      end
    end
  end

  // receiver stalls, with a single long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYC) @(negedge clk_i);
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_vertex(input vertex_t vt, input exp_kind_e kind);
    int n;
    while ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    n = word_cnt + 1;
    typed_kind = kind;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vt.v, vt.u, vt.pz, vt.py, vt.px};
    wait (word_cnt == n);
    @(negedge clk_i);
  endtask

  function automatic vertex_t mk_vtx(input int px, py, pz, u, v);
    vertex_t vt;
    vt.px = POS_W'(px);
    vt.py = POS_W'(py);
    vt.pz = POS_W'(pz);
    vt.u = TEX_W'(u);
    vt.v = TEX_W'(v);
    return vt;
  endfunction

  function automatic vertex_t rand_vtx(input int kind);
    vertex_t vt;
    if (kind == 0) begin
      vt.px = POS_W'($urandom);
      vt.py = POS_W'($urandom);
      vt.pz = POS_W'($urandom);
      vt.u = TEX_W'($urandom);
      vt.v = TEX_W'($urandom);
    end else begin
      vt.px = POS_W'($signed($urandom_range(8191)) - 4096);
      vt.py = POS_W'($signed($urandom_range(8191)) - 4096);
      vt.pz = POS_W'($signed($urandom_range(8191)) - 4096);
      vt.u = TEX_W'($signed($urandom_range(511)) - 256);
      vt.v = TEX_W'($signed($urandom_range(511)) - 256);
    end
    return vt;
  endfunction

  task automatic add_row(input vertex_t vt, input exp_kind_e kind);
    row_t r;
    r.vtx = vt;
    r.kind = kind;
    rows = {rows, r};
  endtask

  initial begin
    vertex_t tri_vtx[3];
    int kind;

    // unit right triangle
    add_row(mk_vtx(0, 0, 0, 0, 0), EXP_NONE);
    add_row(mk_vtx(ONE_P, 0, 0, ONE_T, 0), EXP_NONE);
    add_row(mk_vtx(0, ONE_P, 0, 0, ONE_T), EXP_AXES);
    // zero determinant
    add_row(mk_vtx(5, 7, 9, 100, 200), EXP_NONE);
    add_row(mk_vtx(ONE_P, 3, 0, 100, 200), EXP_NONE);
    add_row(mk_vtx(0, ONE_P, 11, 100, 200), EXP_DEGEN);
    // zero tangent and binormal directions
    add_row(mk_vtx(1234, -99, 77, 0, 0), EXP_NONE);
    add_row(mk_vtx(1234, -99, 77, ONE_T, 0), EXP_NONE);
    add_row(mk_vtx(1234, -99, 77, 0, ONE_T), EXP_DEGEN);
    // tangent parallel to binormal
    add_row(mk_vtx(0, 0, 0, 0, 0), EXP_NONE);
    add_row(mk_vtx(ONE_P, 0, 0, ONE_T, 0), EXP_NONE);
    add_row(mk_vtx(2 * ONE_P, 0, 0, 0, ONE_T), EXP_DEGEN);
    // position extremes
    add_row(mk_vtx(PMIN, PMIN, PMIN, 0, 0), EXP_NONE);
    add_row(mk_vtx(PMAX, PMAX, PMAX, TMAX, 0), EXP_NONE);
    add_row(mk_vtx(PMAX, PMIN, 0, 0, TMAX), EXP_NONE);
    // texture extremes
    add_row(mk_vtx(PMAX, 0, PMIN, TMIN, TMIN), EXP_NONE);
    add_row(mk_vtx(0, PMAX, PMIN, TMAX, TMIN), EXP_NONE);
    add_row(mk_vtx(PMIN, PMAX, 0, TMIN, TMAX), EXP_NONE);
    // negative determinant
    add_row(mk_vtx(0, 0, 0, 0, 0), EXP_NONE);
    add_row(mk_vtx(ONE_P, 0, 0, 0, ONE_T), EXP_NONE);
    add_row(mk_vtx(0, ONE_P, 0, ONE_T, 0), EXP_NONE);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].kind);

    for (int ph = 0; ph < 4; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait (frame_q.size() == 0);
      @(negedge clk_i);
      send_pct = (ph == 1) ? 45 : (ph == 3) ? 23 : 0;
      recv_pct = (ph == 2) ? 45 : (ph == 3) ? 23 : 0;
      for (int t = 0; t < 133; t++) begin
        if (ph == 0 && t == 40) hold_req = 1;
        kind = $urandom_range(9);
        for (int k = 0; k < 3; k++) tri_vtx[k] = rand_vtx(kind < 5 ? 0 : 1);
        if (kind == 8) begin
          tri_vtx[1].u = tri_vtx[0].u;
          tri_vtx[1].v = tri_vtx[0].v;
          tri_vtx[2].u = tri_vtx[0].u;
          tri_vtx[2].v = tri_vtx[0].v;
        end else if (kind == 9) begin
          tri_vtx[1].px = tri_vtx[0].px;
          tri_vtx[1].py = tri_vtx[0].py;
          tri_vtx[1].pz = tri_vtx[0].pz;
        end
        for (int k = 0; k < 3; k++) send_vertex(tri_vtx[k], EXP_NONE);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (frame_q.size() == 0);
    repeat (400) @(negedge clk_i);
    if (err_cnt == 0 && frame_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/ttf_pkg.sv
design/ttf_ctrl.sv
design/ttf_dp.sv
design/triangle_tangent_frame.sv
tb/tb_triangle_tangent_frame.sv
